>>> rtl/bcd_pkg.sv
`default_nettype none
package bcd_pkg;

   localparam int unsigned CoordBits = 14;

   localparam logic [1:0] FMT_BC1 = 2'd0;
   localparam logic [1:0] FMT_BC2 = 2'd1;
   localparam logic [1:0] FMT_BC3 = 2'd2;

   localparam logic REG_FORMAT = 1'b0;
   localparam logic REG_WIDTH  = 1'b1;

   localparam logic [14:0] WIDTH_RESET = 15'd16384;

   typedef struct packed {
      logic [CoordBits-1:0] block_x;
      logic [CoordBits-1:0] block_y;
      logic [63:0]          block_low;
      logic [63:0]          block_high;
   } req_type;

   typedef struct packed {
      logic [CoordBits-1:0] pixel_x;
      logic [CoordBits-1:0] pixel_y;
      logic [31:0]          rgba;
      logic                 last;
   } rsp_type;

   // Palette and alpha table of one block, held while its pixels stream out.
   typedef struct packed {
      logic [3:0][7:0] pal_r;
      logic [3:0][7:0] pal_g;
      logic [3:0][7:0] pal_b;
      logic [7:0][7:0] alpha_tab;
      logic [1:0]      fmt;
      logic [63:0]     low;
      logic [31:0]     idx;
      logic [CoordBits-1:0] bx;
      logic [CoordBits-1:0] by;
      logic [3:0]      keep;
   } blk_type;

   // 5-bit and 6-bit widening with rounding: t = v * 255 + half, then (t + t / 2^n) / 2^n.
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [12:0] t;
      logic [12:0] s;
      t = ({v, 8'd0} - 13'(v)) + 13'd16;
      s = t + 13'(t[12:5]);
      widen5 = s[12:5];
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [13:0] t;
      logic [13:0] s;
      t = ({v, 8'd0} - 14'(v)) + 14'd32;
      s = t + 14'(t[13:6]);
      widen6 = s[13:6];
   endfunction

   // Division of a sum up to 765, 1275 or 1785 by 3, 5 or 7 through reciprocal multiplies.
   function automatic logic [7:0] div3(input logic [9:0] v);
      logic [21:0] p;
      p = 22'(v) * 22'd1366;
      div3 = p[19:12];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] v);
      logic [24:0] p;
      p = 25'(v) * 25'd3277;
      div5 = p[21:14];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] v);
      logic [24:0] p;
      p = 25'(v) * 25'd2341;
      div7 = p[21:14];
   endfunction

endpackage
`default_nettype wire

>>> rtl/bcd_lane.sv
`default_nettype none
// One colour lane: endpoints, then two blends or a midpoint and zero.
module bcd_lane (
   input  wire logic [7:0]      e0,
   input  wire logic [7:0]      e1,
   input  wire logic            four_mode,
   output logic      [3:0][7:0] pal
);
   always_comb begin
      pal[0] = e0;
      pal[1] = e1;
      if (four_mode) begin
         pal[2] = bcd_pkg::div3(10'({e0, 1'b0}) + 10'(e1));
         pal[3] = bcd_pkg::div3(10'(e0) + 10'({e1, 1'b0}));
      end else begin
         pal[2] = 8'((9'(e0) + 9'(e1)) >> 1);
         pal[3] = 8'd0;
      end
   end
endmodule
`default_nettype wire

>>> rtl/bcd_alpha.sv
`default_nettype none
// Eight-entry BC3 alpha table, one lane per code.
module bcd_alpha (
   input  wire logic [7:0]      a0,
   input  wire logic [7:0]      a1,
   output logic      [7:0][7:0] tab
);
   always_comb begin
      tab[0] = a0;
      tab[1] = a1;
      for (int c = 2; c < 8; c++) begin
         if (a0 > a1) begin
            tab[c] = bcd_pkg::div7(11'((8 - c) * a0) + 11'((c - 1) * a1));
         end else if (c == 6) begin
            tab[c] = 8'd0;
         end else if (c == 7) begin
            tab[c] = 8'd255;
         end else begin
            tab[c] = bcd_pkg::div5(11'((6 - c) * a0) + 11'((c - 1) * a1));
         end
      end
   end
endmodule
`default_nettype wire

>>> rtl/bcd_emit.sv
`default_nettype none
// Pixel stepper: walks the held block and emits the kept pixels in order.
module bcd_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire bcd_pkg::blk_type  blk_in,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bcd_pkg::rsp_type       rsp_data
);
   bcd_pkg::blk_type blk_ff;
   logic [3:0] k_ff, k_in;
   logic       act_ff, act_in;
   logic [1:0] col;
   logic [1:0] row;
   logic       kept;
   logic       more;
   logic [1:0] code;
   logic [7:0] alpha;
   logic [3:0] amask;
   logic [2:0] acode;

   assign col  = k_ff[1:0];
   assign row  = k_ff[3:2];
   assign kept = blk_ff.keep[col];
   assign code = blk_ff.idx[{k_ff, 1'b0} +: 2];
   assign amask = blk_ff.low[{k_ff, 2'b00} +: 4];
   assign acode = blk_ff.low[6'd16 + 6'(k_ff) * 6'd3 +: 3];

   // Whether a kept pixel follows the current one within the block.
   always_comb begin
      more = 1'b0;
      for (int c = 0; c < 4; c++) begin
         if (c > col && blk_ff.keep[c]) more = 1'b1;
      end
      if (row != 2'd3 && blk_ff.keep != 4'd0) more = 1'b1;
   end

   always_comb begin
      if (blk_ff.fmt[1]) begin
         alpha = blk_ff.alpha_tab[acode];
      end else if (blk_ff.fmt[0]) begin
         alpha = {amask, amask};
      end else begin
         alpha = 8'd255;
      end
   end

   assign rsp_valid = act_ff && kept;
   assign busy = act_ff && !(rsp_valid && rsp_ready && !more);
   assign rsp_data.pixel_x = blk_ff.bx + bcd_pkg::CoordBits'(col);
   assign rsp_data.pixel_y = blk_ff.by + bcd_pkg::CoordBits'(row);
   assign rsp_data.rgba = {alpha, blk_ff.pal_b[code], blk_ff.pal_g[code], blk_ff.pal_r[code]};
   assign rsp_data.last = !more;

   always_comb begin
      act_in = act_ff;
      k_in = k_ff;
      if (load) begin
         act_in = blk_in.keep != 4'd0;
         k_in = 4'd0;
      end else if (act_ff && (!kept || rsp_ready)) begin
         if (kept && !more) begin
            act_in = 1'b0;
         end
         k_in = k_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         k_ff <= 4'd0;
      end else begin
         act_ff <= act_in;
         k_ff <= k_in;
      end
      if (load) blk_ff <= blk_in;
   end
endmodule
`default_nettype wire

>>> rtl/bc1_bc2_bc3_block_decoder.sv
`default_nettype none
// Channel | Ports      | Carries
// request | req_*      | one compressed block and its position
// result  | rsp_*      | one RGBA pixel
// config  | csr_*      | register index and data
// A block is decoded into palette registers as it is taken, then the pixel stepper visits
// its sixteen positions in order, one a cycle while the result side does not stall,
// emitting the kept ones; it stops at the last kept pixel.
// The next block is taken in the cycle its last pixel is accepted.
// Reset is synchronous; it clears the control state and loads format BC1 and width 16384.
// Stalls on the result side hold the current pixel.
module bc1_bc2_bc3_block_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bcd_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bcd_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [14:0]       csr_data
);
   logic [1:0]  fmt_ff, fmt_in;
   logic [14:0] width_ff, width_in;
   logic        busy;
   logic        load;
   logic        is1;
   logic [63:0] cb;
   logic [15:0] c0, c1;
   bcd_pkg::blk_type blk;

   assign csr_ready = 1'b1;
   assign req_ready = !busy;
   assign load = req_valid && req_ready;

   always_comb begin
      fmt_in = fmt_ff;
      width_in = width_ff;
      if (csr_valid) begin
         case (csr_index)
            bcd_pkg::REG_FORMAT: fmt_in = csr_data[1:0];
            bcd_pkg::REG_WIDTH:  width_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= bcd_pkg::FMT_BC1;
         width_ff <= bcd_pkg::WIDTH_RESET;
      end else begin
         fmt_ff <= fmt_in;
         width_ff <= width_in;
      end
   end

   assign is1 = !fmt_ff[1] && !fmt_ff[0];
   assign cb = is1 ? req_data.block_low : req_data.block_high;
   assign c0 = cb[15:0];
   assign c1 = cb[31:16];

   bcd_lane u_red (
      .e0(bcd_pkg::widen5(c0[15:11])), .e1(bcd_pkg::widen5(c1[15:11])),
      .four_mode(!is1 || c0 > c1), .pal(blk.pal_r));
   bcd_lane u_green (
      .e0(bcd_pkg::widen6(c0[10:5])), .e1(bcd_pkg::widen6(c1[10:5])),
      .four_mode(!is1 || c0 > c1), .pal(blk.pal_g));
   bcd_lane u_blue (
      .e0(bcd_pkg::widen5(c0[4:0])), .e1(bcd_pkg::widen5(c1[4:0])),
      .four_mode(!is1 || c0 > c1), .pal(blk.pal_b));
   bcd_alpha u_alpha (
      .a0(req_data.block_low[7:0]), .a1(req_data.block_low[15:8]), .tab(blk.alpha_tab));

   always_comb begin
      blk.fmt = fmt_ff;
      blk.low = req_data.block_low;
      blk.idx = cb[63:32];
      blk.bx = req_data.block_x;
      blk.by = req_data.block_y;
      for (int c = 0; c < 4; c++) begin
         blk.keep[c] = 15'(req_data.block_x) + 15'(c) < width_ff;
      end
   end

   bcd_emit u_emit (
      .clock(clock), .reset(reset), .load(load), .blk_in(blk), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
endmodule
`default_nettype wire

>>> tb/sv/bc1_bc2_bc3_block_decoder_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bc1_bc2_bc3_block_decoder_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire bcd_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire bcd_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic             csr_index,
   input  wire logic [14:0]      csr_data,
   output int                    fail_count,
   output int                    pixels_pending
);
   logic [1:0]        fmt_shadow;
   logic [14:0]       width_shadow;
   bcd_pkg::rsp_type  pixel_queue[$];

   function automatic logic [7:0] expand5(input logic [4:0] v);
      int t;
      t = v * 255 + 16;
      return 8'((t / 32 + t) / 32);
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] v);
      int t;
      t = v * 255 + 32;
      return 8'((t / 64 + t) / 64);
   endfunction

   function automatic logic [7:0] interp_alpha(input logic [63:0] ab, input int k);
      int a0, a1, c;
      a0 = ab[7:0];
      a1 = ab[15:8];
      c = (ab >> (16 + 3 * k)) & 7;
      if (c == 0) return 8'(a0);
      if (c == 1) return 8'(a1);
      if (a0 > a1) return 8'(((8 - c) * a0 + (c - 1) * a1) / 7);
      if (c == 6) return 8'd0;
      if (c == 7) return 8'd255;
      return 8'(((6 - c) * a0 + (c - 1) * a1) / 5);
   endfunction

   task automatic decode_block(input bcd_pkg::req_type blk);
      int pr[4], pg[4], pb[4], c0, c1, code, col, a;
      logic [63:0] cb;
      logic [31:0] idx;
      logic is3, is2;
      bcd_pkg::rsp_type px;
      bcd_pkg::rsp_type pixels[$];
      is3 = fmt_shadow[1];
      is2 = !is3 && fmt_shadow[0];
      cb = (is3 || is2) ? blk.block_high : blk.block_low;
      idx = cb[63:32];
      c0 = cb[15:0];
      c1 = cb[31:16];
      pr[0] = expand5(c0 >> 11); pg[0] = expand6((c0 >> 5) & 6'h3f); pb[0] = expand5(c0 & 5'h1f);
      pr[1] = expand5(c1 >> 11); pg[1] = expand6((c1 >> 5) & 6'h3f); pb[1] = expand5(c1 & 5'h1f);
      if (is3 || is2 || c0 > c1) begin
         pr[2] = (2 * pr[0] + pr[1]) / 3; pg[2] = (2 * pg[0] + pg[1]) / 3;
         pb[2] = (2 * pb[0] + pb[1]) / 3;
         pr[3] = (pr[0] + 2 * pr[1]) / 3; pg[3] = (pg[0] + 2 * pg[1]) / 3;
         pb[3] = (pb[0] + 2 * pb[1]) / 3;
      end else begin
         pr[2] = (pr[0] + pr[1]) / 2; pg[2] = (pg[0] + pg[1]) / 2; pb[2] = (pb[0] + pb[1]) / 2;
         pr[3] = 0; pg[3] = 0; pb[3] = 0;
      end
      for (int k = 0; k < 16; k++) begin
         col = int'(blk.block_x) + (k % 4);
         if (col >= width_shadow) continue;
         code = (idx >> (2 * k)) & 3;
         if (is3) a = interp_alpha(blk.block_low, k);
         else if (is2) a = ((blk.block_low >> (4 * k)) & 4'hf) * 17;
         else a = 255;
         px.pixel_x = bcd_pkg::CoordBits'(col);
         px.pixel_y = bcd_pkg::CoordBits'(int'(blk.block_y) + k / 4);
         px.rgba = {8'(a), 8'(pb[code]), 8'(pg[code]), 8'(pr[code])};
         px.last = 1'b0;
         pixels.push_back(px);
      end
      if (pixels.size() > 0) pixels[pixels.size() - 1].last = 1'b1;
      foreach (pixels[i]) pixel_queue.push_back(pixels[i]);
   endtask

   always @(posedge clock) begin
      bcd_pkg::rsp_type want;
      if (reset) begin
         fmt_shadow <= bcd_pkg::FMT_BC1;
         width_shadow <= bcd_pkg::WIDTH_RESET;
         pixel_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == bcd_pkg::REG_FORMAT) fmt_shadow <= csr_data[1:0];
            else width_shadow <= csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               $error("unexpected pixel x=%0d y=%0d", rsp_data.pixel_x, rsp_data.pixel_y);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_data.pixel_x !== want.pixel_x) begin
                  $error("pixel_x expected %0d got %0d", want.pixel_x, rsp_data.pixel_x);
                  fail_count <= fail_count + 1;
               end
               if (rsp_data.pixel_y !== want.pixel_y) begin
                  $error("pixel_y expected %0d got %0d", want.pixel_y, rsp_data.pixel_y);
                  fail_count <= fail_count + 1;
               end
               if (rsp_data.rgba !== want.rgba) begin
                  $error("rgba expected %h got %h", want.rgba, rsp_data.rgba);
                  fail_count <= fail_count + 1;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, rsp_data.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // Requests are decoded after the pop so their pixels queue behind older ones.
         if (req_valid && req_ready) decode_block(req_data);
      end
   end

   assign pixels_pending = pixel_queue.size();
endmodule
`default_nettype wire

>>> tb/sv/bc1_bc2_bc3_block_decoder_test.sv
`timescale 1ns / 1ps
`default_nettype none
module bc1_bc2_bc3_block_decoder_test;
   logic              clock;
   logic              reset;
   logic              req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   bcd_pkg::req_type  req_data;
   bcd_pkg::rsp_type  rsp_data;
   logic              csr_index;
   logic [14:0]       csr_data;
   int                fail_count, pixels_pending;
   bit                calm, hold_rsp;

   bc1_bc2_bc3_block_decoder dut (.*);
   bc1_bc2_bc3_block_decoder_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   // The receiver stalls at random, except in calm stretches, and once for a long hold.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && (calm || $urandom_range(99) >= 30);
   end

   task automatic write_reg(input logic idx, input logic [14:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Valid stays high from one request to the next unless an idle gap is drawn.
   task automatic send_block(input logic [13:0] x, input logic [13:0] y,
                             input logic [63:0] lo, input logic [63:0] hi);
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= '{block_x: x, block_y: y, block_low: lo, block_high: hi};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_blocks(input int count, input logic [14:0] width);
      logic [13:0] x;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) x = 14'($urandom);
         else x = 14'($urandom_range(width / 4 + 1) * 4);
         send_block(x, 14'($urandom), rand64(), rand64());
      end
   endtask

   initial begin
      logic [14:0] widths[4];
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      csr_valid = 1'b0; csr_index = bcd_pkg::REG_FORMAT; csr_data = '0;
      calm = 1'b0; hold_rsp = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: BC1 four- and three-colour modes, extremes, wrap-around.
      send_block(14'd0, 14'd0, 64'h0, 64'h0);
      send_block(14'h3fff, 14'h3fff, '1, '1);
      send_block(14'd16380, 14'd16380, 64'hE4E4E4E4_0000FFFF, '0);
      send_block(14'd4, 14'd8, 64'hFFFFFFFF_F80007E0, '0);
      send_block(14'd5, 14'd3, 64'h1B1B1B1B_FFFF0000, '1);
      drain();

      widths = '{15'd0, 15'd1, 15'd6, 15'h7fff};
      foreach (widths[w]) begin
         write_reg(bcd_pkg::REG_WIDTH, widths[w]);
         for (int f = 0; f < 4; f++) begin
            // Format code three also decodes as BC3.
            write_reg(bcd_pkg::REG_FORMAT, 15'(f));
            send_block(14'd0, 14'd0, 64'hFAC688FAC688_00FF, 64'h1B1B1B1B_001F07E0);
            send_block(14'd4, 14'd4, 64'hFAC688FAC688_FF00, 64'hE4E4E4E4_F81F07E0);
            drain();
         end
      end

      write_reg(bcd_pkg::REG_WIDTH, 15'd16384);
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(bcd_pkg::REG_FORMAT, 15'($urandom_range(3)));
         write_reg(bcd_pkg::REG_WIDTH, phase == 1 ? 15'd9 : 15'($urandom_range(1, 16384)));
         calm = (phase == 2);
         if (phase == 3) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 1'b0;
               end
               random_blocks(25, 15'd64);
            join
         end else random_blocks(20, phase == 1 ? 15'd9 : 15'd16384);
         drain();
      end
      calm = 1'b0;

      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
